### rtl/image_rotate_inverse_map_macros.svh
// ----------------------------------------------------------------------------
// image_rotate_inverse_map_macros
// Assertion macros shared by the rotation block.
// ----------------------------------------------------------------------------
`ifndef IMAGE_ROTATE_INVERSE_MAP_MACROS_SVH
`define IMAGE_ROTATE_INVERSE_MAP_MACROS_SVH

// same-cycle implication
`define IRIM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IRIM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/irim_pkg.sv
// ----------------------------------------------------------------------------
// irim_pkg
// Types, widths and constants of the image rotation block.
// ----------------------------------------------------------------------------
package irim_pkg;

   // default sizing
   localparam int DEF_MAX_WIDTH      = 256;
   localparam int DEF_MAX_HEIGHT     = 256;
   localparam int DEF_TRIG_FRAC_BITS = 14;

   // field widths
   localparam int POS_W   = 9;
   localparam int PIXEL_W = 16;
   localparam int TRIG_W  = 16;
   localparam int SIZE_W  = 9;
   localparam int BOX_OUT_W = 10;

   // corner product: unsigned size (as 10-bit signed) times trig value
   localparam int CORNER_PROD_W = SIZE_W + 1 + TRIG_W;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COS_Q14    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SIN_Q14    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BACK_COLOR = 3'd4;

   localparam logic [SIZE_W-1:0]         RST_SRC_WIDTH  = 9'd256;
   localparam logic [SIZE_W-1:0]         RST_SRC_HEIGHT = 9'd256;
   localparam logic signed [TRIG_W-1:0]  RST_COS_Q14    = 16'sd16384;
   localparam logic signed [TRIG_W-1:0]  RST_SIN_Q14    = 16'sd0;
   localparam logic [PIXEL_W-1:0]        RST_BACK_COLOR = 16'd63519;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [PIXEL_W-1:0] pixel_in;
   } req_data_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]   pixel_out;
      logic                 covered;
      logic [BOX_OUT_W-1:0] out_width;
      logic [BOX_OUT_W-1:0] out_height;
   } rsp_data_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic wr_pixel;
      logic corner_mul;
      logic corner_sum;
      logic box;
      logic offset;
      logic map_mul;
      logic map_sum;
      logic addr;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_is_read;
      logic out_busy;
   } status_type;

endpackage

### rtl/irim_ram.sv
// ----------------------------------------------------------------------------
// irim_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module irim_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/irim_ctrl.sv
// ----------------------------------------------------------------------------
// irim_ctrl
// Sequencer that steps one request at a time through the datapath.
// ----------------------------------------------------------------------------
module irim_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  irim_pkg::status_type  status,
   output irim_pkg::cmd_type     cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_WRITE  = 4'd1;
   localparam logic [3:0] ST_CMUL   = 4'd2;
   localparam logic [3:0] ST_CSUM   = 4'd3;
   localparam logic [3:0] ST_BOX    = 4'd4;
   localparam logic [3:0] ST_OFFSET = 4'd5;
   localparam logic [3:0] ST_MMUL   = 4'd6;
   localparam logic [3:0] ST_MSUM   = 4'd7;
   localparam logic [3:0] ST_ADDR   = 4'd8;
   localparam logic [3:0] ST_READ   = 4'd9;
   localparam logic [3:0] ST_LOAD   = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.req_is_read ? ST_CMUL : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.wr_pixel = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_CMUL: begin
            cmd.corner_mul = 1'b1;
            state_in       = ST_CSUM;
         end
         ST_CSUM: begin
            cmd.corner_sum = 1'b1;
            state_in       = ST_BOX;
         end
         ST_BOX: begin
            cmd.box  = 1'b1;
            state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            cmd.offset = 1'b1;
            state_in   = ST_MMUL;
         end
         ST_MMUL: begin
            cmd.map_mul = 1'b1;
            state_in    = ST_MSUM;
         end
         ST_MSUM: begin
            cmd.map_sum = 1'b1;
            state_in    = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.addr = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            // ram read in flight
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // wait for the result register to free up
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`include "image_rotate_inverse_map_macros.svh"

   `IRIM_ASSERT_NOW(a_one_step, clock, reset, 1'b1, $onehot0({cmd.wr_pixel, cmd.corner_mul, cmd.corner_sum, cmd.box, cmd.offset, cmd.map_mul, cmd.map_sum, cmd.addr, cmd.load_out}), "more than one datapath step issued")
   `IRIM_ASSERT_NEXT(a_busy_after_take, clock, reset, cmd.capture, req_stall, "second transfer taken while busy")
   `IRIM_ASSERT_NOW(a_write_follows_take, clock, reset, cmd.wr_pixel, $past(cmd.capture), "pixel write without a preceding transfer")

endmodule

### rtl/irim_datapath.sv
// ----------------------------------------------------------------------------
// irim_datapath
// Config registers, bounding box, inverse mapping, image memory and result.
// ----------------------------------------------------------------------------
module irim_datapath #(
   parameter int MAX_WIDTH      = irim_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT     = irim_pkg::DEF_MAX_HEIGHT,
   parameter int TRIG_FRAC_BITS = irim_pkg::DEF_TRIG_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [irim_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [irim_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  irim_pkg::req_data_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output irim_pkg::rsp_data_type              rsp_data,
   input  irim_pkg::cmd_type                   cmd,
   output irim_pkg::status_type                status
);

   localparam int SIZE_W   = irim_pkg::SIZE_W;
   localparam int TRIG_W   = irim_pkg::TRIG_W;
   localparam int PIXEL_W  = irim_pkg::PIXEL_W;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CP_W     = irim_pkg::CORNER_PROD_W;
   localparam int CS_W     = CP_W + 1;
   localparam int CORNER_W = CS_W - TRIG_FRAC_BITS + 1;
   localparam int BOX_W    = CORNER_W + 1;
   localparam int XY_W     = ((CORNER_W > SIZE_W + 1) ? CORNER_W : SIZE_W + 1) + 1;
   localparam int MP_W     = XY_W + TRIG_W;
   localparam int MS_W     = MP_W + 1;
   localparam int SRC_W    = MS_W - TRIG_FRAC_BITS + 1;

   // truncation toward zero of a fixed-point sum
   function automatic logic signed [CS_W-1:0] trunc_cs(input logic signed [CS_W-1:0] v);
      logic signed [CS_W-1:0] bias;
      bias = v[CS_W-1] ? CS_W'((1 << TRIG_FRAC_BITS) - 1) : '0;
      return (v + bias) >>> TRIG_FRAC_BITS;
   endfunction

   function automatic logic signed [MS_W-1:0] trunc_ms(input logic signed [MS_W-1:0] v);
      logic signed [MS_W-1:0] bias;
      bias = v[MS_W-1] ? MS_W'((1 << TRIG_FRAC_BITS) - 1) : '0;
      return (v + bias) >>> TRIG_FRAC_BITS;
   endfunction

   function automatic logic signed [CORNER_W-1:0] min4(
      input logic signed [CORNER_W-1:0] a,
      input logic signed [CORNER_W-1:0] b,
      input logic signed [CORNER_W-1:0] c,
      input logic signed [CORNER_W-1:0] d
   );
      logic signed [CORNER_W-1:0] m;
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      if (d < m) m = d;
      return m;
   endfunction

   function automatic logic signed [CORNER_W-1:0] max4(
      input logic signed [CORNER_W-1:0] a,
      input logic signed [CORNER_W-1:0] b,
      input logic signed [CORNER_W-1:0] c,
      input logic signed [CORNER_W-1:0] d
   );
      logic signed [CORNER_W-1:0] m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      if (d > m) m = d;
      return m;
   endfunction

   function automatic logic [irim_pkg::BOX_OUT_W-1:0] sat_box(
      input logic signed [BOX_W-1:0] v
   );
      return (int'(v) > 1023) ? 10'd1023 : irim_pkg::BOX_OUT_W'(v);
   endfunction

   // configuration registers
   logic [SIZE_W-1:0]        src_width_ff;
   logic [SIZE_W-1:0]        src_height_ff;
   logic signed [TRIG_W-1:0] cos_ff;
   logic signed [TRIG_W-1:0] sin_ff;
   logic [PIXEL_W-1:0]       back_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= irim_pkg::RST_SRC_WIDTH;
         src_height_ff <= irim_pkg::RST_SRC_HEIGHT;
         cos_ff        <= irim_pkg::RST_COS_Q14;
         sin_ff        <= irim_pkg::RST_SIN_Q14;
         back_color_ff <= irim_pkg::RST_BACK_COLOR;
      end else if (csr_write_en) begin
         case (csr_index)
            irim_pkg::REG_SRC_WIDTH:  src_width_ff  <= csr_wdata[SIZE_W-1:0];
            irim_pkg::REG_SRC_HEIGHT: src_height_ff <= csr_wdata[SIZE_W-1:0];
            irim_pkg::REG_COS_Q14:    cos_ff        <= $signed(csr_wdata);
            irim_pkg::REG_SIN_Q14:    sin_ff        <= $signed(csr_wdata);
            irim_pkg::REG_BACK_COLOR: back_color_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // effective image size, clamped to the memory
   logic [SIZE_W-1:0]        w_eff;
   logic [SIZE_W-1:0]        h_eff;
   logic signed [SIZE_W:0]   w_s;
   logic signed [SIZE_W:0]   h_s;

   assign w_eff = (int'(src_width_ff) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : src_width_ff;
   assign h_eff = (int'(src_height_ff) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : src_height_ff;
   assign w_s   = $signed({1'b0, w_eff});
   assign h_s   = $signed({1'b0, h_eff});

   // captured request
   irim_pkg::req_data_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   assign status.req_is_read = (req_data.req_type == irim_pkg::REQ_READ);

   // source pixel write
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;

   assign wr_en   = cmd.wr_pixel && (int'(req_ff.pos_x) < int'(w_eff))
                    && (int'(req_ff.pos_y) < int'(h_eff));
   assign wr_addr = ADDR_W'(ROW_W'(req_ff.pos_y)) * ADDR_W'(MAX_WIDTH)
                    + ADDR_W'(COL_W'(req_ff.pos_x));

   // corner products
   logic signed [CP_W-1:0] p_hs_ff, p_hc_ff, p_wc_ff, p_ws_ff;
   logic signed [CP_W-1:0] p_hs_in, p_hc_in, p_wc_in, p_ws_in;

   assign p_hs_in = CP_W'(h_s) * CP_W'(sin_ff);
   assign p_hc_in = CP_W'(h_s) * CP_W'(cos_ff);
   assign p_wc_in = CP_W'(w_s) * CP_W'(cos_ff);
   assign p_ws_in = CP_W'(w_s) * CP_W'(sin_ff);

   // rotated corners (0,h), (w,h), (w,0)
   logic signed [CORNER_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff;
   logic signed [CORNER_W-1:0] x1_in, y1_in, x2_in, y2_in, x3_in, y3_in;

   assign x1_in = CORNER_W'(trunc_cs(CS_W'(p_hs_ff)));
   assign y1_in = CORNER_W'(trunc_cs(CS_W'(p_hc_ff)));
   assign x2_in = CORNER_W'(trunc_cs(CS_W'(p_wc_ff) + CS_W'(p_hs_ff)));
   assign y2_in = CORNER_W'(trunc_cs(CS_W'(p_hc_ff) - CS_W'(p_ws_ff)));
   assign x3_in = CORNER_W'(trunc_cs(CS_W'(p_wc_ff)));
   assign y3_in = CORNER_W'(trunc_cs(-CS_W'(p_ws_ff)));

   // bounding box
   logic signed [CORNER_W-1:0] minx_ff, miny_ff, minx_in, miny_in;
   logic signed [BOX_W-1:0]    bw_ff, bh_ff, bw_in, bh_in;

   assign minx_in = min4('0, x1_ff, x2_ff, x3_ff);
   assign miny_in = min4('0, y1_ff, y2_ff, y3_ff);
   assign bw_in   = BOX_W'(max4('0, x1_ff, x2_ff, x3_ff)) - BOX_W'(minx_in);
   assign bh_in   = BOX_W'(max4('0, y1_ff, y2_ff, y3_ff)) - BOX_W'(miny_in);

   // output pixel relative to the rotation origin
   logic signed [XY_W-1:0] x_ff, y_ff, x_in, y_in;
   logic                   in_box_ff, in_box_in;

   assign x_in = XY_W'($signed({1'b0, req_ff.pos_x})) + XY_W'(minx_ff);
   assign y_in = XY_W'($signed({1'b0, req_ff.pos_y})) + XY_W'(miny_ff);
   assign in_box_in = (int'(req_ff.pos_x) < int'(bw_ff)) && (int'(req_ff.pos_y) < int'(bh_ff));

   // inverse rotation products
   logic signed [MP_W-1:0] q_xc_ff, q_ys_ff, q_yc_ff, q_xs_ff;
   logic signed [MP_W-1:0] q_xc_in, q_ys_in, q_yc_in, q_xs_in;

   assign q_xc_in = MP_W'(x_ff) * MP_W'(cos_ff);
   assign q_ys_in = MP_W'(y_ff) * MP_W'(sin_ff);
   assign q_yc_in = MP_W'(y_ff) * MP_W'(cos_ff);
   assign q_xs_in = MP_W'(x_ff) * MP_W'(sin_ff);

   // source position
   logic signed [SRC_W-1:0] sx_ff, sy_ff, sx_in, sy_in;

   assign sx_in = SRC_W'(trunc_ms(MS_W'(q_xc_ff) - MS_W'(q_ys_ff)));
   assign sy_in = SRC_W'(trunc_ms(MS_W'(q_yc_ff) + MS_W'(q_xs_ff)));

   // coverage and read address
   logic              cov_ff, cov_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [PIXEL_W-1:0] rd_data;

   assign cov_in = in_box_ff && (sx_ff >= 0) && (sy_ff >= 0)
                   && (int'(sx_ff) < int'(w_eff)) && (int'(sy_ff) < int'(h_eff));
   // address only meaningful when covered
   assign rd_addr_in = ADDR_W'($unsigned(ROW_W'(sy_ff))) * ADDR_W'(MAX_WIDTH)
                       + ADDR_W'($unsigned(COL_W'(sx_ff)));

   always_ff @(posedge clock) begin
      if (cmd.corner_mul) begin
         p_hs_ff <= p_hs_in;
         p_hc_ff <= p_hc_in;
         p_wc_ff <= p_wc_in;
         p_ws_ff <= p_ws_in;
      end
      if (cmd.corner_sum) begin
         x1_ff <= x1_in;
         y1_ff <= y1_in;
         x2_ff <= x2_in;
         y2_ff <= y2_in;
         x3_ff <= x3_in;
         y3_ff <= y3_in;
      end
      if (cmd.box) begin
         minx_ff <= minx_in;
         miny_ff <= miny_in;
         bw_ff   <= bw_in;
         bh_ff   <= bh_in;
      end
      if (cmd.offset) begin
         x_ff      <= x_in;
         y_ff      <= y_in;
         in_box_ff <= in_box_in;
      end
      if (cmd.map_mul) begin
         q_xc_ff <= q_xc_in;
         q_ys_ff <= q_ys_in;
         q_yc_ff <= q_yc_in;
         q_xs_ff <= q_xs_in;
      end
      if (cmd.map_sum) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
      if (cmd.addr) begin
         cov_ff     <= cov_in;
         rd_addr_ff <= rd_addr_in;
      end
   end

   irim_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_image_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ff.pixel_in),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   irim_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & rsp_stall);

   always_comb begin
      rsp_data_in.pixel_out  = cov_ff ? rd_data : back_color_ff;
      rsp_data_in.covered    = cov_ff;
      rsp_data_in.out_width  = sat_box(bw_ff);
      rsp_data_in.out_height = sat_box(bh_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.out_busy = rsp_valid_ff & rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

`include "image_rotate_inverse_map_macros.svh"

   `IRIM_ASSERT_NOW(a_result_from_load, clock, reset, $rose(rsp_valid_ff), $past(cmd.load_out), "result appeared without a load step")

endmodule

### rtl/image_rotate_inverse_map.sv
// ----------------------------------------------------------------------------
// image_rotate_inverse_map
// Nearest-neighbor image rotation by inverse mapping, RGB565 pixels.
//
// Write requests store one source pixel and give no result; after its
// transfer a write takes a single write step before the block returns to
// idle and takes the next request. Read requests give one result each: the
// request transfer is followed by nine steps of the sequencer (corner
// products, corners, bounding box, offset, inverse products, source position,
// address, memory read, result load), and the next request is taken only
// after the last of them. The controller walks each read through the
// registered datapath stages one per cycle, ending in the registered read
// port of the image memory. A new request is taken while a finished result
// still waits in the output register; the sequencer only holds in its last
// step if the earlier result has not yet been taken. The image memory has no
// reset; pixels that were never written read back undefined. Configuration
// may be written only while the block is idle.
// ----------------------------------------------------------------------------
module image_rotate_inverse_map #(
   parameter int MAX_WIDTH      = irim_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT     = irim_pkg::DEF_MAX_HEIGHT,
   parameter int TRIG_FRAC_BITS = irim_pkg::DEF_TRIG_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [irim_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [irim_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  irim_pkg::req_data_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output irim_pkg::rsp_data_type             rsp_data
);

   irim_pkg::cmd_type    cmd;
   irim_pkg::status_type status;

   irim_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   irim_datapath #(
      .MAX_WIDTH      (MAX_WIDTH),
      .MAX_HEIGHT     (MAX_HEIGHT),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

### tb/sv/rotate_result_checker.sv
// ----------------------------------------------------------------------------
// rotate_result_checker
// Watches the request, result and register ports of the rotation block. It
// keeps its own copy of the source image and the register settings, works
// out the expected result of every read transfer and compares each result
// transfer field by field with the oldest pending expectation.
// ----------------------------------------------------------------------------
module rotate_result_checker
   import irim_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_data_type           req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_data_type           rsp_data,
   output int unsigned            mismatch_count,
   output int unsigned            pending_reads
);

   localparam int     IMG_W   = DEF_MAX_WIDTH;
   localparam int     IMG_H   = DEF_MAX_HEIGHT;
   localparam longint Q_ONE   = longint'(1) << DEF_TRIG_FRAC_BITS;
   localparam longint BOX_MAX = (longint'(1) << BOX_OUT_W) - 1;

   logic [SIZE_W-1:0]        src_w;
   logic [SIZE_W-1:0]        src_h;
   logic signed [TRIG_W-1:0] cos_v;
   logic signed [TRIG_W-1:0] sin_v;
   logic [PIXEL_W-1:0]       back_v;
   logic [PIXEL_W-1:0]       src_image [IMG_W*IMG_H];
   rsp_data_type             rotated_pixel_q [$];
   int unsigned              results_seen;

   initial begin
      mismatch_count = 0;
      pending_reads  = 0;
      results_seen   = 0;
   end

   task automatic report_error(input string what);
      $display("checker: result %0d: %s", results_seen, what);
      mismatch_count++;
   endtask

   // signed division truncates toward zero
   function automatic longint trunc_q(input longint v);
      return v / Q_ONE;
   endfunction

   function automatic longint clamp_size(input longint v, input longint lim);
      return (v > lim) ? lim : v;
   endfunction

   function automatic longint min_of4(input longint a, b, c, d);
      longint m;
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      if (d < m) m = d;
      return m;
   endfunction

   function automatic longint max_of4(input longint a, b, c, d);
      longint m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      if (d > m) m = d;
      return m;
   endfunction

   function automatic rsp_data_type predict_rotated_pixel(input logic [POS_W-1:0] out_x,
                                                          input logic [POS_W-1:0] out_y);
      longint       wi, hi, c, s;
      longint       x1, y1, x2, y2, x3, y3;
      longint       min_x, min_y, box_w, box_h;
      longint       x, y, sx, sy;
      rsp_data_type r;
      wi = clamp_size(src_w, IMG_W);
      hi = clamp_size(src_h, IMG_H);
      c  = cos_v;
      s  = sin_v;
      // rotated corners (0,h), (w,h), (w,0); (0,0) stays at the origin
      x1 = trunc_q(hi * s);
      y1 = trunc_q(hi * c);
      x2 = trunc_q(wi * c + hi * s);
      y2 = trunc_q(hi * c - wi * s);
      x3 = trunc_q(wi * c);
      y3 = trunc_q(-wi * s);
      min_x = min_of4(0, x1, x2, x3);
      min_y = min_of4(0, y1, y2, y3);
      box_w = max_of4(0, x1, x2, x3) - min_x;
      box_h = max_of4(0, y1, y2, y3) - min_y;
      r.pixel_out  = back_v;
      r.covered    = 1'b0;
      r.out_width  = (box_w > BOX_MAX) ? BOX_MAX[BOX_OUT_W-1:0] : box_w[BOX_OUT_W-1:0];
      r.out_height = (box_h > BOX_MAX) ? BOX_MAX[BOX_OUT_W-1:0] : box_h[BOX_OUT_W-1:0];
      if (longint'(out_x) < box_w && longint'(out_y) < box_h) begin
         x  = longint'(out_x) + min_x;
         y  = longint'(out_y) + min_y;
         sx = trunc_q(x * c - y * s);
         sy = trunc_q(y * c + x * s);
         if (sx >= 0 && sy >= 0 && sx < wi && sy < hi) begin
            r.pixel_out = src_image[sy * IMG_W + sx];
            r.covered   = 1'b1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_data_type want;
      if (reset) begin
         src_w  <= RST_SRC_WIDTH;
         src_h  <= RST_SRC_HEIGHT;
         cos_v  <= RST_COS_Q14;
         sin_v  <= RST_SIN_Q14;
         back_v <= RST_BACK_COLOR;
         rotated_pixel_q.delete();
         pending_reads <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_SRC_WIDTH:  src_w  <= csr_wdata[SIZE_W-1:0];
               REG_SRC_HEIGHT: src_h  <= csr_wdata[SIZE_W-1:0];
               REG_COS_Q14:    cos_v  <= csr_wdata[TRIG_W-1:0];
               REG_SIN_Q14:    sin_v  <= csr_wdata[TRIG_W-1:0];
               REG_BACK_COLOR: back_v <= csr_wdata[PIXEL_W-1:0];
               default: ;
            endcase
         end
         // compare before queuing, so a stray result is never matched to a new read
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rotated_pixel_q.size() == 0) begin
               report_error($sformatf("result with no read pending, pixel_out %h",
                                      rsp_data.pixel_out));
            end else begin
               want = rotated_pixel_q.pop_front();
               if (rsp_data.pixel_out !== want.pixel_out)
                  report_error($sformatf("pixel_out got %h expected %h",
                                         rsp_data.pixel_out, want.pixel_out));
               if (rsp_data.covered !== want.covered)
                  report_error($sformatf("covered got %b expected %b",
                                         rsp_data.covered, want.covered));
               if (rsp_data.out_width !== want.out_width)
                  report_error($sformatf("out_width got %0d expected %0d",
                                         rsp_data.out_width, want.out_width));
               if (rsp_data.out_height !== want.out_height)
                  report_error($sformatf("out_height got %0d expected %0d",
                                         rsp_data.out_height, want.out_height));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.req_type == REQ_WRITE) begin
               if (longint'(req_data.pos_x) < clamp_size(src_w, IMG_W) &&
                   longint'(req_data.pos_y) < clamp_size(src_h, IMG_H))
                  src_image[req_data.pos_y * IMG_W + req_data.pos_x] = req_data.pixel_in;
            end else begin
               rotated_pixel_q.push_back(predict_rotated_pixel(req_data.pos_x,
                                                               req_data.pos_y));
            end
         end
         pending_reads <= rotated_pixel_q.size();
      end
   end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the image rotation block. A corner of the source
// image is loaded first and random image sizes stay inside it, so every later
// read maps to a written pixel. A short directed part covers size
// saturation, an empty image, ignored writes, reads outside the box and box
// saturation; random phases follow, each with fresh register settings,
// mostly reads aimed inside the reported box and random pixel overwrites.
// Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_top;
   import irim_pkg::*;

   localparam int          STALL_LIMIT     = 1000;
   localparam int          SETTLE_CYCLES   = 12;
   localparam int          RAND_PHASES     = 12;
   localparam int          ITEMS_PER_PHASE = 72;
   localparam int          LOAD_SIZE       = 32;
   localparam int          IMG_W           = DEF_MAX_WIDTH;
   localparam int          IMG_H           = DEF_MAX_HEIGHT;
   localparam real         PI              = 3.1415926;
   localparam real         FULL_TURN_DEG   = 360.0;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   req_data_type           req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   rsp_data_type           rsp_data;

   int unsigned            mismatch_count;
   int unsigned            pending_reads;
   int unsigned            idle_cycles  = 0;
   int unsigned            stall_run    = 0;
   bit                     quiet_mode   = 1'b0;
   int unsigned            cur_w        = IMG_W;
   int unsigned            cur_h        = IMG_H;
   int unsigned            last_box_w   = 0;
   int unsigned            last_box_h   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   image_rotate_inverse_map DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   rotate_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_reads  (pending_reads)
   );

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_data_type make_req(input logic kind, input logic [POS_W-1:0] x,
                                             input logic [POS_W-1:0] y,
                                             input logic [PIXEL_W-1:0] pix);
      req_data_type r;
      r.req_type = kind;
      r.pos_x    = x;
      r.pos_y    = y;
      r.pixel_in = pix;
      return r;
   endfunction

   // mostly inside the last reported box, its edge included
   function automatic logic [POS_W-1:0] pick_read_pos(input int unsigned extent);
      if (extent == 0 || $urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 511));
      return POS_W'($urandom_range(0, (extent > 511) ? 511 : extent));
   endfunction

   function automatic logic [POS_W-1:0] pick_write_pos(input int unsigned limit);
      if (limit == 0 || $urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 511));
      return POS_W'($urandom_range(0, limit - 1));
   endfunction

   // sizes stay within the loaded corner
   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 7))
         0:       return SIZE_W'(1);
         1:       return SIZE_W'(LOAD_SIZE);
         2:       return SIZE_W'($urandom_range(LOAD_SIZE / 2, LOAD_SIZE));
         3, 4:    return SIZE_W'($urandom_range(1, 24));
         default: return SIZE_W'($urandom_range(0, LOAD_SIZE));
      endcase
   endfunction

   function automatic logic [TRIG_W-1:0] pick_trig_corner();
      case ($urandom_range(0, 4))
         0:       return 16'h4000;
         1:       return 16'hC000;
         2:       return 16'h0000;
         3:       return 16'h7FFF;
         default: return 16'h8000;
      endcase
   endfunction

   // valid stays high back to back when there is no gap
   task automatic send_req(input req_data_type item);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reads != 0) @(posedge clock);
   endtask

   // writes leave no result, so give the pipeline time to drain
   task automatic wait_idle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                input logic [TRIG_W-1:0] c, input logic [TRIG_W-1:0] s,
                                input logic [PIXEL_W-1:0] bg);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index    <= REG_SRC_WIDTH;
      csr_wdata    <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index    <= REG_SRC_HEIGHT;
      csr_wdata    <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_index    <= REG_COS_Q14;
      csr_wdata    <= c;
      @(posedge clock);
      csr_index    <= REG_SIN_Q14;
      csr_wdata    <= s;
      @(posedge clock);
      csr_index    <= REG_BACK_COLOR;
      csr_wdata    <= bg;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_w = (w > IMG_W) ? IMG_W : w;
      cur_h = (h > IMG_H) ? IMG_H : h;
   endtask

   task automatic random_setting();
      logic [TRIG_W-1:0] c;
      logic [TRIG_W-1:0] s;
      real               ang;
      int unsigned       mode;
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
         ang = $urandom_range(0, int'(FULL_TURN_DEG) - 1) * 2.0 * PI / FULL_TURN_DEG;
         c   = TRIG_W'($rtoi(16384.0 * $cos(ang)));
         s   = TRIG_W'($rtoi(16384.0 * $sin(ang)));
      end else if (mode < 8) begin
         c = pick_trig_corner();
         s = pick_trig_corner();
      end else begin
         c = TRIG_W'($urandom);
         s = TRIG_W'($urandom);
      end
      apply_setting(pick_size(), pick_size(), c, s, PIXEL_W'($urandom));
   endtask

   // box size as reported, used only to aim reads
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         last_box_w <= rsp_data.out_width;
         last_box_h <= rsp_data.out_height;
      end
   end

   always @(posedge clock) begin : rsp_stall_gen
      int unsigned n;
      if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else begin
         n = pick_gap();
         rsp_stall <= (n != 0);
         stall_run <= (n != 0) ? n - 1 : $urandom_range(0, 5);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= STALL_LIMIT);
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // load the top-left corner once; later reads only map into it
      for (int row = 0; row < LOAD_SIZE; row++) begin
         quiet_mode = (row % 8 != 0);
         for (int col = 0; col < LOAD_SIZE; col++)
            send_req(make_req(REQ_WRITE, POS_W'(col), POS_W'(row), PIXEL_W'($urandom)));
      end
      quiet_mode = 1'b0;

      // reset settings: identity at full size, corners and outside the box
      send_req(make_req(REQ_READ,  9'd0,   9'd0,   16'h0000));
      send_req(make_req(REQ_READ,  9'd31,  9'd31,  16'hFFFF));
      send_req(make_req(REQ_READ,  9'd256, 9'd0,   16'h0000));
      send_req(make_req(REQ_READ,  9'd511, 9'd511, 16'hFFFF));
      send_req(make_req(REQ_WRITE, 9'd0,   9'd0,   16'hFFFF));
      send_req(make_req(REQ_WRITE, 9'd255, 9'd255, 16'h0000));
      send_req(make_req(REQ_WRITE, 9'd256, 9'd5,   16'h1234));
      send_req(make_req(REQ_WRITE, 9'd7,   9'd511, 16'h4321));
      send_req(make_req(REQ_READ,  9'd0,   9'd0,   16'h0000));
      send_req(make_req(REQ_READ,  9'd255, 9'd255, 16'h0000));

      // sizes above the maximum, half turn
      apply_setting(9'd511, 9'd300, 16'hC000, 16'h0000, 16'h0000);
      send_req(make_req(REQ_READ, 9'd0,   9'd0,   16'h0000));
      send_req(make_req(REQ_READ, 9'd255, 9'd255, 16'h0000));
      send_req(make_req(REQ_READ, 9'd240, 9'd250, 16'h0000));

      // empty image, quarter turn
      apply_setting(9'd0, 9'd0, 16'h0000, 16'h4000, 16'hFFFF);
      send_req(make_req(REQ_WRITE, 9'd0, 9'd0, 16'hAAAA));
      send_req(make_req(REQ_READ,  9'd0, 9'd0, 16'h0000));
      send_req(make_req(REQ_READ,  9'd1, 9'd0, 16'h0000));

      // trig beyond unit range, box saturates
      apply_setting(9'd256, 9'd256, 16'h8000, 16'h8000, 16'h5555);
      send_req(make_req(REQ_READ, 9'd511, 9'd511, 16'h0000));
      send_req(make_req(REQ_READ, 9'd0,   9'd0,   16'h0000));
      send_req(make_req(REQ_READ, 9'd300, 9'd100, 16'h0000));

      // single pixel image
      apply_setting(9'd1, 9'd1, 16'h7FFF, 16'h7FFF, 16'h0001);
      send_req(make_req(REQ_READ,  9'd0, 9'd0, 16'h0000));
      send_req(make_req(REQ_READ,  9'd1, 9'd1, 16'h0000));
      send_req(make_req(REQ_WRITE, 9'd0, 9'd0, 16'h8001));
      send_req(make_req(REQ_READ,  9'd0, 9'd0, 16'h0000));

      for (int p = 0; p < RAND_PHASES; p++) begin
         quiet_mode = (p % 4 == 1);
         random_setting();
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p % 2 == 0 && i == ITEMS_PER_PHASE / 2)
               wait_results();
            if ($urandom_range(0, 9) < 7)
               send_req(make_req(REQ_READ, pick_read_pos(last_box_w),
                                 pick_read_pos(last_box_h), PIXEL_W'($urandom)));
            else
               send_req(make_req(REQ_WRITE, pick_write_pos(cur_w),
                                 pick_write_pos(cur_h), PIXEL_W'($urandom)));
         end
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
